[rtl/core/olst_pkg.sv]
// Package for the ordered list store: request and response item types,
// request kind and status codes, cell operation codes and default sizes.
// Used by olst_cell and ordered_list_store_top.
package olst_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FIELD_W = 5;
  localparam int unsigned STAT_W  = 2;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_APPEND      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH_HEAD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH_TAIL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR       = 3'd5;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD       = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd3;

  // What a cell loads at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [FIELD_W-1:0]        position;
  } olst_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] found_position;
    logic [FIELD_W-1:0] length;
  } olst_rsp_t;

endpackage

[rtl/core/olst_cell.sv]
// One cell of the list chain: holds one element, shifts it to or from its
// neighbors and compares it against the broadcast search value.
// Depends on olst_pkg.
module olst_cell import olst_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  cell_op_e              op_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  match_o
);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  always_comb begin
    unique case (op_i)
      CELL_HOLD:  data_d = data_q;
      CELL_LOAD:  data_d = value_i;
      CELL_LEFT:  data_d = left_i;
      CELL_RIGHT: data_d = right_i;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == value_i);

endmodule

[rtl/core/ordered_list_store_top.sv]
// Top level of the ordered list store: request decode, the chain of list
// cells, match priority encoding and the response register.
// Depends on olst_pkg and olst_cell.
//
// Usage: a request item (kind, value, position) enters on the req channel
// and exactly one response item (status, found_position, length) leaves on
// the rsp channel, both with valid/ready handshakes. The list lives in a row
// of CAPACITY cells; cell k holds the element at position k+1. An insert or
// remove moves every cell at or past the target by one place toward its
// neighbor at the same clock edge, and a search compares all cells at once,
// so any request completes in the execute state, whatever its kind or length.
// The request is registered and executed in the execute state, which writes
// the response register; the block accepts no new request before that write.
// The execute state waits while a previous response is still held by a stalled
// receiver; the response register then keeps its item until it is taken.
// Reset empties the list (length zero) and drops any request or response
// in flight; the cell contents need no reset because only cells below the
// length are ever read.
module ordered_list_store_top import olst_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  olst_req_t req_i,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output olst_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_q, state_d;
  olst_req_t             req_q;
  logic [CNT_W-1:0]      count_q, count_d;
  olst_rsp_t             rsp_q, rsp_d;
  logic                  rsp_valid_q, rsp_valid_d;
  logic                  advance;

  logic [DATA_WIDTH-1:0] value_x;
  logic [CMP_W-1:0]      cnt_x, pos_x, tgt;
  logic                  ins_en, rem_en, full;
  logic [STAT_W-1:0]     status;
  logic [CNT_W-1:0]      found_pos;

  logic [DATA_WIDTH-1:0] data_w [CAPACITY];
  logic [CAPACITY-1:0]   match_w;
  logic [CAPACITY-1:0]   hit;
  cell_op_e              cell_op [CAPACITY];
  logic [IDX_W-1:0]      head_idx, tail_idx;
  logic                  any_hit;

  // Handshake: one request in flight at a time.
  assign req_ready_o = (state_q == ST_IDLE);
  assign advance     = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready_i);

  // Only the low DATA_WIDTH bits are stored and compared.
  assign value_x = DATA_WIDTH'(req_q.value);
  assign cnt_x   = CMP_W'(count_q);
  assign pos_x   = CMP_W'(req_q.position);
  assign full    = (count_q >= CNT_W'(CAPACITY));

  // Match vector restricted to the occupied cells.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = match_w[i] && (CMP_W'(i) < cnt_x);
    end
  end

  // First and last matching cell.
  always_comb begin
    head_idx = '0;
    tail_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        head_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        tail_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit = |hit;

  // Request decode: status, new length and the cell shift target.
  always_comb begin
    ins_en    = 1'b0;
    rem_en    = 1'b0;
    tgt       = '0;
    status    = STATUS_BAD;
    found_pos = '0;
    count_d   = count_q;
    unique case (req_q.kind)
      KIND_APPEND: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          status = STATUS_DONE;
          ins_en = 1'b1;
          tgt    = cnt_x;
        end
      end
      KIND_INSERT: begin
        if (count_q == '0 || pos_x > cnt_x) begin
          status = STATUS_BAD;
        end else if (full) begin
          status = STATUS_FULL;
        end else begin
          status = STATUS_DONE;
          ins_en = 1'b1;
          tgt    = pos_x;
        end
      end
      KIND_REMOVE: begin
        if (count_q == '0 || pos_x == '0 || pos_x > cnt_x) begin
          status = STATUS_BAD;
        end else begin
          status = STATUS_DONE;
          rem_en = 1'b1;
          tgt    = pos_x - CMP_W'(1);
        end
      end
      KIND_SEARCH_HEAD, KIND_SEARCH_TAIL: begin
        if (count_q == '0) begin
          status = STATUS_BAD;
        end else if (!any_hit) begin
          status = STATUS_NOT_FOUND;
        end else begin
          status    = STATUS_DONE;
          found_pos = (req_q.kind == KIND_SEARCH_HEAD)
                    ? CNT_W'(head_idx) + CNT_W'(1)
                    : CNT_W'(tail_idx) + CNT_W'(1);
        end
      end
      KIND_CLEAR: begin
        status = STATUS_DONE;
      end
      default: begin
        status = STATUS_BAD;
      end
    endcase
    if (ins_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (rem_en) begin
      count_d = count_q - CNT_W'(1);
    end else if (req_q.kind == KIND_CLEAR) begin
      count_d = '0;
    end
  end

  // Per-cell shift control.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = CELL_HOLD;
      if (advance && ins_en) begin
        if (CMP_W'(i) > tgt) begin
          cell_op[i] = CELL_LEFT;
        end else if (CMP_W'(i) == tgt) begin
          cell_op[i] = CELL_LOAD;
        end
      end else if (advance && rem_en) begin
        if (CMP_W'(i) >= tgt) begin
          cell_op[i] = CELL_RIGHT;
        end
      end
    end
  end

  // The cell chain. Cell 0 never takes from the left; the last cell never
  // takes from the right in a way that matters, since it lies past the
  // new length after a remove.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = value_x;
    end else begin : g_mid
      assign left_w = data_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = data_w[g];
    end else begin : g_inner
      assign right_w = data_w[g+1];
    end
    olst_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op[g]),
      .value_i(value_x),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (data_w[g]),
      .match_o(match_w[g])
    );
  end

  // Control next state and response register.
  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (advance) begin
          state_d              = ST_IDLE;
          rsp_valid_d          = 1'b1;
          rsp_d.status         = status;
          rsp_d.found_position = FIELD_W'(found_pos);
          rsp_d.length         = FIELD_W'(count_d);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (advance) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
